[rtl/core/pocf_pkg.sv]
// shared types and constants of the posting occurrence count filter
package pocf_pkg;

	// payload and register widths
	localparam int DOC_W       = 16;
	localparam int CNT_OUT_W   = 16;
	localparam int SKIP_W      = 8;
	localparam int OVERLAP_W   = 16;
	localparam int PREFIX_W    = 11;
	localparam int COMBO_W     = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	// threshold: overlap times two prefix factors
	localparam int THR_W       = OVERLAP_W + 2 * PREFIX_W;
	localparam int DIVISOR_W   = 3;

	// output queue
	localparam int OQ_DEPTH    = 3;
	localparam int OQ_PW       = $clog2(OQ_DEPTH);
	localparam int OQ_OW       = $clog2(OQ_DEPTH + 1);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SKIP    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PREFIX  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COMBO   = 2'd3;

	// register reset values
	localparam logic [SKIP_W-1:0]    SKIP_RST    = 8'd1;
	localparam logic [OVERLAP_W-1:0] OVERLAP_RST = 16'd2;
	localparam logic [PREFIX_W-1:0]  PREFIX_RST  = 11'd32;
	localparam logic [COMBO_W-1:0]   COMBO_RST   = 2'd2;

	// command codes
	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// combination sizes and their divisors
	localparam logic [COMBO_W-1:0]   COMBO_PAIR     = 2'd2;
	localparam logic [COMBO_W-1:0]   COMBO_TRIPLE   = 2'd3;
	localparam logic [DIVISOR_W-1:0] DIV_TRIPLE     = 3'd6;
	localparam logic [DIVISOR_W-1:0] DIV_PAIR       = 3'd2;
	localparam logic [DIVISOR_W-1:0] DIV_SINGLE     = 3'd1;

	typedef struct packed {
		logic [SKIP_W-1:0]    skip;
		logic [OVERLAP_W-1:0] overlap;
		logic [PREFIX_W-1:0]  prefix;
		logic [COMBO_W-1:0]   combo;
	} cfg_t;

	typedef struct packed {
		logic [DOC_W-1:0]     doc;
		logic                 cand;
		logic [CNT_OUT_W-1:0] count;
	} res_t;

endpackage

[rtl/core/pocf_ram.sv]
// generic single-port-write, single-port-read ram with registered read
module pocf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port, read returns old data on collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/pocf_thresh.sv]
// multi-cycle threshold unit: overlap times the prefix factors, and the divisor for 1, 2 or 3 pivots
module pocf_thresh import pocf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  cfg_t                 cfg,
	output logic                 busy,
	output logic [THR_W-1:0]     thr,
	output logic [DIVISOR_W-1:0] divisor
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL1 = 2'd1;
	localparam logic [1:0] ST_MUL2 = 2'd2;
	localparam int         MF_W    = OVERLAP_W + PREFIX_W;

	logic [1:0]           state_q;
	logic [OVERLAP_W-1:0] m_q;
	logic [PREFIX_W-1:0]  f1_q;
	logic [PREFIX_W-1:0]  f2_q;
	logic [DIVISOR_W-1:0] d_q;
	logic [MF_W-1:0]      mf_q;
	logic [THR_W-1:0]     thr_q;
	logic [DIVISOR_W-1:0] div_q;

	logic [PREFIX_W-1:0]  fac_a;
	logic [PREFIX_W-1:0]  fac_b;
	logic [PREFIX_W-1:0]  f1_n;
	logic [PREFIX_W-1:0]  f2_n;
	logic [DIVISOR_W-1:0] d_n;

	// prefix factors, clamped at zero for short prefixes
	always_comb begin
		fac_a = (cfg.prefix != '0) ? cfg.prefix - PREFIX_W'(1) : '0;
		fac_b = (cfg.prefix >= PREFIX_W'(2)) ? cfg.prefix - PREFIX_W'(2) : '0;
		case (cfg.combo)
			COMBO_TRIPLE: begin
				f1_n = fac_a;
				f2_n = fac_b;
				d_n  = DIV_TRIPLE;
			end
			COMBO_PAIR: begin
				f1_n = fac_a;
				f2_n = PREFIX_W'(1);
				d_n  = DIV_PAIR;
			end
			default: begin
				f1_n = PREFIX_W'(1);
				f2_n = PREFIX_W'(1);
				d_n  = DIV_SINGLE;
			end
		endcase
	end

	// sequencer, a new start restarts the multiplies
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else if (start) begin
			state_q <= ST_MUL1;
		end else begin
			case (state_q)
				ST_MUL1: begin
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath: capture operands, then two multiplies
	always_ff @(posedge clk) begin
		if (start) begin
			m_q  <= cfg.overlap;
			f1_q <= f1_n;
			f2_q <= f2_n;
			d_q  <= d_n;
		end else begin
			case (state_q)
				ST_MUL1: begin
					mf_q <= MF_W'(m_q) * MF_W'(f1_q);
				end
				ST_MUL2: begin
					thr_q <= THR_W'(mf_q) * THR_W'(f2_q);
					div_q <= d_q;
				end
				default: begin
				end
			endcase
		end
	end

	assign busy    = (state_q != ST_IDLE);
	assign thr     = thr_q;
	assign divisor = div_q;

endmodule

[rtl/core/pocf_oq.sv]
// small output queue that decouples the result word from the receiver
module pocf_oq import pocf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  res_t             push_data,
	output logic [OQ_OW-1:0] occ,
	output logic             out_valid,
	input  logic             out_ready,
	output res_t             out_data
);

	res_t             ent_q [OQ_DEPTH];
	logic [OQ_PW-1:0] wr_ptr_q;
	logic [OQ_PW-1:0] rd_ptr_q;
	logic [OQ_OW-1:0] occ_q;
	logic             pop;

	assign pop = out_valid && out_ready;

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == OQ_PW'(OQ_DEPTH - 1)) ? '0 : wr_ptr_q + OQ_PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == OQ_PW'(OQ_DEPTH - 1)) ? '0 : rd_ptr_q + OQ_PW'(1);
			end
			occ_q <= occ_q + OQ_OW'(push) - OQ_OW'(pop);
		end
	end

	assign occ       = occ_q;
	assign out_valid = (occ_q != '0);
	assign out_data  = ent_q[rd_ptr_q];

endmodule

[rtl/core/posting_occurrence_count_filter.sv]
// top level of the posting occurrence count filter
//
// Input channel (in_valid/in_ready, cmd, doc_index): cmd add raises the
// counter of doc_index by skip_step, saturating; cmd read returns the
// counter and clears it. Adds give no result word; each read gives one
// word on the output channel (out_valid/out_ready, doc_out, is_candidate,
// count_value), in order. is_candidate compares the count with a
// threshold built from overlap_needed, prefix_length and combo_size.
// Counters live in one ram with a registered read; a read-modify-write
// writes back from stage 1 as the read data arrives, and a write-to-read
// forward covers an item that hits the same document on the next cycle,
// so one word per cycle is taken while in_ready is high. A read's result
// is pushed to the output queue from stage 1. After reset the block
// sweeps all DOC_COUNT counters (65536 at the default) to zero with
// in_ready low. After reset and every register write in_ready stays low
// while a start step and two multiplies build the undivided product; the
// count times the divisor, plus the divisor less one, is compared against
// it. A stalled receiver fills a three-word output queue; in_ready drops
// once the queue plus a read in flight could overflow it.
module posting_occurrence_count_filter import pocf_pkg::*; #(
	parameter int DOC_COUNT  = 65536,
	parameter int COUNT_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  cmd,
	input  logic [DOC_W-1:0]      doc_index,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DOC_W-1:0]      doc_out,
	output logic                  is_candidate,
	output logic [CNT_OUT_W-1:0]  count_value
);

	localparam int AW = $clog2(DOC_COUNT);
	localparam int XW = ((AW > DOC_W) ? AW : DOC_W) + 1;
	localparam int SW = ((COUNT_BITS > SKIP_W) ? COUNT_BITS : SKIP_W) + 1;
	localparam int QW = ((COUNT_BITS + DIVISOR_W > THR_W) ? COUNT_BITS + DIVISOR_W : THR_W);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	// configuration registers
	cfg_t cfg_q;
	logic start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.skip    <= SKIP_RST;
			cfg_q.overlap <= OVERLAP_RST;
			cfg_q.prefix  <= PREFIX_RST;
			cfg_q.combo   <= COMBO_RST;
			start_q       <= 1'b1;
		end else begin
			start_q <= cfg_we;
			if (cfg_we) begin
				case (cfg_index)
					CFG_SKIP:    cfg_q.skip    <= cfg_wdata[SKIP_W-1:0];
					CFG_OVERLAP: cfg_q.overlap <= cfg_wdata[OVERLAP_W-1:0];
					CFG_PREFIX:  cfg_q.prefix  <= cfg_wdata[PREFIX_W-1:0];
					CFG_COMBO:   cfg_q.combo   <= cfg_wdata[COMBO_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	// threshold unit
	logic                 thr_busy;
	logic [THR_W-1:0]     thr;
	logic [DIVISOR_W-1:0] thr_div;

	pocf_thresh u_thresh (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_q),
		.cfg     (cfg_q),
		.busy    (thr_busy),
		.thr     (thr),
		.divisor (thr_div)
	);

	// clearing sweep after reset
	logic          clr_q;
	logic [AW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			if (clr_addr_q == AW'(DOC_COUNT - 1)) begin
				clr_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	// input decode
	logic [XW-1:0] doc_ext;
	logic          in_range;
	logic [AW-1:0] doc_addr;
	logic          accept;

	assign doc_ext  = XW'(doc_index);
	assign in_range = (doc_ext < XW'(DOC_COUNT));
	assign doc_addr = doc_ext[AW-1:0];
	assign accept   = in_valid && in_ready;

	// stage 1 registers: item waiting for its ram read
	logic             v_s1;
	logic             cmd_s1;
	logic [DOC_W-1:0] doc_s1;
	logic             inr_s1;
	logic [AW-1:0]    addr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= cmd;
			doc_s1  <= doc_index;
			inr_s1  <= in_range;
			addr_s1 <= doc_addr;
		end
	end

	// counter ram
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [COUNT_BITS-1:0] ram_wdata;
	logic [COUNT_BITS-1:0] ram_rdata;
	logic                  wr_en;
	logic [COUNT_BITS-1:0] wr_data;

	assign ram_we    = clr_q || wr_en;
	assign ram_waddr = clr_q ? clr_addr_q : addr_s1;
	assign ram_wdata = clr_q ? '0 : wr_data;

	pocf_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (DOC_COUNT)
	) u_cnt_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (doc_addr),
		.rdata (ram_rdata)
	);

	// forward of the last write, which the ram read of the next item misses
	logic                  fw_v_s2;
	logic [AW-1:0]         fw_addr_s2;
	logic [COUNT_BITS-1:0] fw_data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_v_s2 <= 1'b0;
		end else begin
			fw_v_s2 <= wr_en;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fw_addr_s2 <= addr_s1;
			fw_data_s2 <= wr_data;
		end
	end

	// modify: saturating add or clear on read
	logic [COUNT_BITS-1:0] cur;
	logic [SW-1:0]         sum;
	logic [COUNT_BITS-1:0] sat;

	always_comb begin
		cur     = (fw_v_s2 && (fw_addr_s2 == addr_s1)) ? fw_data_s2 : ram_rdata;
		sum     = SW'(cur) + SW'(cfg_q.skip);
		sat     = (sum > SW'(CNT_MAX)) ? CNT_MAX : COUNT_BITS'(sum);
		wr_en   = v_s1 && inr_s1;
		wr_data = (cmd_s1 == CMD_READ) ? '0 : sat;
	end

	// result word of a read
	logic          push;
	res_t          push_data;
	logic [QW-1:0] cur_ext;
	logic [QW-1:0] cur_scaled;

	// count >= floor(p / d) exactly when count * d + d - 1 >= p
	always_comb begin
		cur_ext = QW'(cur);
		case (thr_div)
			DIV_TRIPLE: cur_scaled = (cur_ext << 2) + (cur_ext << 1) +
			                         QW'(DIV_TRIPLE - DIV_SINGLE);
			DIV_PAIR:   cur_scaled = (cur_ext << 1) + QW'(DIV_PAIR - DIV_SINGLE);
			default:    cur_scaled = cur_ext;
		endcase
		push            = v_s1 && (cmd_s1 == CMD_READ);
		push_data.doc   = doc_s1;
		push_data.cand  = inr_s1 && (cur_scaled >= QW'(thr));
		push_data.count = inr_s1 ? CNT_OUT_W'(cur) : '0;
	end

	// output queue
	logic [OQ_OW-1:0] occ;
	res_t             out_data;

	pocf_oq u_oq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.occ       (occ),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign doc_out      = out_data.doc;
	assign is_candidate = out_data.cand;
	assign count_value  = out_data.count;

	// input ready: no sweep, threshold settled, room for a word in flight
	logic [OQ_OW:0] credit;

	assign credit   = {1'b0, occ} + (OQ_OW + 1)'(push);
	assign in_ready = !clr_q && !thr_busy && !start_q && !cfg_we &&
	                  (credit <= (OQ_OW + 1)'(OQ_DEPTH - 1));

endmodule

[rtl/core/pocf_checker.sv]
// port-level checks of the posting occurrence count filter, bound to the top level
module pocf_checker import pocf_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_we,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  cmd,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [DOC_W-1:0]      doc_out,
	input logic                  is_candidate,
	input logic [CNT_OUT_W-1:0]  count_value
);

	// a result word only appears once an accepted read has passed stage 1 and the output queue
	a_out_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && (cmd == CMD_READ), 2))
		else $error("result word without a read accepted two cycles before");

	// no item taken while a register is written
	a_no_accept_on_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !in_ready)
		else $error("input ready during a register write");

	// threshold recompute holds off input right after a register write
	a_hold_after_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cfg_we) |-> !in_ready)
		else $error("input ready while the threshold is being rebuilt");

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(doc_out) &&
		$stable(is_candidate) && $stable(count_value))
		else $error("result word changed while stalled");

endmodule

bind posting_occurrence_count_filter pocf_checker u_pocf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cfg_we       (cfg_we),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.cmd          (cmd),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.doc_out      (doc_out),
	.is_candidate (is_candidate),
	.count_value  (count_value)
);
